/* rtl/swmf_pkg.sv */
// Shared types and constants for the sliding window median filter.
// No dependencies; imported by swmf_ctrl, swmf_datapath and the top level.
`default_nettype none

package swmf_pkg;

  localparam int DEFAULT_WINDOW_SIZE = 8;
  localparam int SAMPLE_W            = 16;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic store;     // write the accepted item into the window
    logic scan;      // issue the next rank candidate
    logic load_out;  // load the result register
  } swmf_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;      // window holds WINDOW_SIZE samples
    logic last_idx;  // candidate index is on the final entry
  } swmf_status_t;

endpackage : swmf_pkg

`default_nettype wire

/* rtl/swmf_datapath.sv */
// Datapath: cyclic sample window, rank scan over the window and result register.
// Depends on swmf_pkg for the command/status structs and sample width.
`default_nettype none

module swmf_datapath #(
  parameter int WINDOW_SIZE = swmf_pkg::DEFAULT_WINDOW_SIZE
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire swmf_pkg::swmf_cmd_t             cmd,
  output      swmf_pkg::swmf_status_t          status,
  input  wire logic [swmf_pkg::SAMPLE_W-1:0]   sample,
  output      logic [swmf_pkg::SAMPLE_W-1:0]   median,
  output      logic                            window_full
);
  import swmf_pkg::*;

  localparam int IW = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
  localparam int CW = $clog2(WINDOW_SIZE + 1);
  localparam logic [IW-1:0] LAST_SLOT = IW'(WINDOW_SIZE - 1);
  localparam logic [CW-1:0] FILL_MAX  = CW'(WINDOW_SIZE);
  localparam logic [CW-1:0] K_LO      = CW'(WINDOW_SIZE / 2 - 1);
  localparam logic [CW-1:0] K_HI      = CW'(WINDOW_SIZE / 2);
  localparam bit            ODD_SIZE  = (WINDOW_SIZE % 2) == 1;

  logic [SAMPLE_W-1:0]    win [WINDOW_SIZE];
  logic [IW-1:0]          slot;
  logic [CW-1:0]          fill;
  logic [IW-1:0]          idx;
  logic                   s1_valid;
  logic [SAMPLE_W-1:0]    s1_cand;
  logic [WINDOW_SIZE-1:0] s1_lt;
  logic [WINDOW_SIZE-1:0] s1_le;
  logic [SAMPLE_W-1:0]    lo_val;
  logic [SAMPLE_W-1:0]    hi_val;
  logic [SAMPLE_W-1:0]    cand;
  logic [WINDOW_SIZE-1:0] lt_vec;
  logic [WINDOW_SIZE-1:0] le_vec;
  logic [CW-1:0]          lt_cnt;
  logic [CW-1:0]          le_cnt;
  logic [SAMPLE_W:0]      pair_sum;
  logic [SAMPLE_W-1:0]    med_val;

  assign status.full     = (fill == FILL_MAX);
  assign status.last_idx = (idx == LAST_SLOT);

  // Compare the candidate against every entry in parallel.
  assign cand = win[idx];
  always_comb begin
    for (int j = 0; j < WINDOW_SIZE; j++) begin
      lt_vec[j] = win[j] <  cand;
      le_vec[j] = win[j] <= cand;
    end
  end

  assign lt_cnt = CW'($countones(s1_lt));
  assign le_cnt = CW'($countones(s1_le));

  assign pair_sum = {1'b0, lo_val} + {1'b0, hi_val};
  assign med_val  = ODD_SIZE ? hi_val : pair_sum[SAMPLE_W:1];

  always_ff @(posedge clk) begin
    if (rst) begin
      slot     <= '0;
      fill     <= '0;
      idx      <= '0;
      s1_valid <= 1'b0;
    end else begin
      if (cmd.store) begin
        win[slot] <= sample;
        slot      <= (slot == LAST_SLOT) ? '0 : slot + 1'b1;
        if (fill != FILL_MAX) begin
          fill <= fill + 1'b1;
        end
      end
      s1_valid <= cmd.scan;
      if (cmd.scan) begin
        idx <= status.last_idx ? '0 : idx + 1'b1;
      end
    end
  end

  // Payload registers: rank stage and result register.
  always_ff @(posedge clk) begin
    if (cmd.scan) begin
      s1_cand <= cand;
      s1_lt   <= lt_vec;
      s1_le   <= le_vec;
    end
    // A candidate sits at sorted position k when lt <= k < le.
    if (s1_valid) begin
      if (lt_cnt <= K_LO && K_LO < le_cnt) begin
        lo_val <= s1_cand;
      end
      if (lt_cnt <= K_HI && K_HI < le_cnt) begin
        hi_val <= s1_cand;
      end
    end
    if (cmd.load_out) begin
      median      <= status.full ? med_val : '0;
      window_full <= status.full;
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst) fill <= FILL_MAX)
    else $error("fill count beyond window size");
  a_slot_bound: assert property (@(posedge clk) disable iff (rst) slot <= LAST_SLOT)
    else $error("write slot beyond window");
  a_store_not_scan: assert property (@(posedge clk) disable iff (rst)
                                     !(cmd.store && (cmd.scan || s1_valid)))
    else $error("window written during rank scan");

endmodule : swmf_datapath

`default_nettype wire

/* rtl/swmf_ctrl.sv */
// Controller: sequences store, rank scan (once the window is full) and result load for each item.
// Depends on swmf_pkg for the command/status structs.
`default_nettype none

module swmf_ctrl (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    sample_valid,
  output      logic                    sample_stall,
  output      logic                    result_valid,
  input  wire logic                    result_stall,
  output      swmf_pkg::swmf_cmd_t     cmd,
  input  wire swmf_pkg::swmf_status_t  status
);
  import swmf_pkg::*;

  typedef enum logic [2:0] {
    IDLE,
    CHECK,
    SCAN,
    DRAIN,
    DONE
  } state_t;

  state_t state;
  logic   accept;
  logic   out_free;

  assign accept   = sample_valid && !sample_stall;
  assign out_free = !result_valid || !result_stall;

  always_comb begin
    cmd          = '0;
    cmd.store    = accept;
    cmd.scan     = (state == SCAN);
    cmd.load_out = (state == DONE) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= IDLE;
      sample_stall <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      // drop the taken result unless a new one replaces it this cycle
      if (result_valid && !result_stall && !cmd.load_out) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (accept) begin
            state        <= CHECK;
            sample_stall <= 1'b1;
          end
        end
        CHECK: begin
          state <= status.full ? SCAN : DONE;
        end
        SCAN: begin
          if (status.last_idx) begin
            state <= DRAIN;
          end
        end
        DRAIN: begin
          // last rank candidate settles here
          state <= DONE;
        end
        DONE: begin
          if (out_free) begin
            result_valid <= 1'b1;
            sample_stall <= 1'b0;
            state        <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
                                   cmd.load_out |-> (!result_valid || !result_stall))
    else $error("pending result overwritten");
  a_accept_check: assert property (@(posedge clk) disable iff (rst)
                                   accept |=> (state == CHECK))
    else $error("accepted item not checked next cycle");
  a_scan_end: assert property (@(posedge clk) disable iff (rst)
                               (state == SCAN && status.last_idx) |=> (state == DRAIN))
    else $error("rank scan overran the window");
  a_busy_stall: assert property (@(posedge clk) disable iff (rst)
                                 (state != IDLE) |-> sample_stall)
    else $error("input open while busy");

endmodule : swmf_ctrl

`default_nettype wire

/* rtl/sliding_window_median_filter.sv */
// Sliding window median filter: each sample item gives one result item.
// Input channel sample_valid/sample_stall carries sample; output channel
// result_valid/result_stall carries median and window_full.
// Each accepted sample fills the next window slot, overwriting the oldest
// entry once the window is full. Until WINDOW_SIZE samples have arrived the
// result is median 0 with window_full low; after that it is the median of the
// window (mean of the two middle values, floored, for an even size).
// One item is in work at a time: the next sample is taken only after the result
// of the last one has been loaded. While filling, an item passes the check state
// and the result load; once full, the check is followed by the rank scan, which
// ranks one window entry per cycle against all entries, then a count stage and
// the result load.
// The result sits in an output register; a stalled result holds there while
// the next sample is taken and scanned, and that next result waits for it.
// Reset (rst, synchronous) empties the window and drops any pending result.
// Depends on swmf_pkg, swmf_ctrl and swmf_datapath.
`default_nettype none

module sliding_window_median_filter #(
  parameter int WINDOW_SIZE = swmf_pkg::DEFAULT_WINDOW_SIZE
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           sample_valid,
  output      logic                           sample_stall,
  input  wire logic [swmf_pkg::SAMPLE_W-1:0]  sample,
  output      logic                           result_valid,
  input  wire logic                           result_stall,
  output      logic [swmf_pkg::SAMPLE_W-1:0]  median,
  output      logic                           window_full
);
  import swmf_pkg::*;

  swmf_cmd_t    cmd;
  swmf_status_t status;

  swmf_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .cmd          (cmd),
    .status       (status)
  );

  swmf_datapath #(
    .WINDOW_SIZE (WINDOW_SIZE)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .sample      (sample),
    .median      (median),
    .window_full (window_full)
  );

endmodule : sliding_window_median_filter

`default_nettype wire
